// File: sv/oilspd_pkg.sv
// Shared types and constants for the oil sensor pulse decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package oilspd_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TWIDTH_W    = 18;
  localparam int unsigned TEMP_W      = 12;
  localparam int unsigned LEVEL_W     = 14;
  localparam int unsigned TPULSE_W    = 20;
  localparam int unsigned LINT_W      = 24;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 80;

  // interpolation datapath
  localparam int unsigned Y_W   = 16;              // signed y values and result
  localparam int unsigned MAG_W = 14;              // |y2 - y1|, also quotient width
  localparam int unsigned DX_W  = 24;              // x - x1 and x2 - x1
  localparam int unsigned PROD_W = MAG_W + DX_W;
  localparam int unsigned STEP_W = 4;              // divider step counter

  localparam logic [TIME_W-1:0] WIDTH_MIN_US = 32'd10000;
  localparam logic [TIME_W-1:0] WIDTH_MAX_US = 32'd220000;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_PULSE_LOW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_PULSE_HIGH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW         = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH        = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_INT_LOW    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_INT_HIGH   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW        = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH       = 8'd7;

  typedef struct packed {
    logic        [TPULSE_W-1:0] temp_pulse_low_us;
    logic        [TPULSE_W-1:0] temp_pulse_high_us;
    logic signed [TEMP_W-1:0]   temp_low_tenths;
    logic signed [TEMP_W-1:0]   temp_high_tenths;
    logic        [LINT_W-1:0]   level_interval_low_us;
    logic        [LINT_W-1:0]   level_interval_high_us;
    logic        [LEVEL_W-1:0]  level_low_tenths;
    logic        [LEVEL_W-1:0]  level_high_tenths;
  } cfg_t;

  // one temperature pulse waiting for interpolation
  typedef struct packed {
    logic [TWIDTH_W-1:0] temp_width_us;
    logic                level_present;
    logic [TIME_W-1:0]   level_interval_us;
  } job_t;

endpackage

// File: sv/oil_sensor_pulse_decoder_top.sv
// Oil sensor pulse decoder: edge words in, temperature/level words out.
// Path: a falling-edge word queues a job; each map is stored directly when clamped, or goes
// through the shared multiplier and one pass of the 14-step divider when in range.
// Throughput: one edge word per cycle until the job queue fills; pulses are interpolated
// one at a time, and a result that out_tready holds back stalls the next pulse.
// Reset: rst_n sync, active low; clears rise times, queue, output valid; loads cal defaults.
`timescale 1ns / 1ps

module oil_sensor_pulse_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = oilspd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [oilspd_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] edge_time_us
  input  logic                               in_tuser,   // [0] pin_high
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [11:0] temp_tenths, [29:12] temp_width_us, [43:30] level_tenths,
  // [75:44] level_interval_us, [79:76] zero
  output logic [oilspd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser,  // [0] level_present
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [oilspd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [oilspd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import oilspd_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t             cfg_r;
  logic             push;
  job_t             push_job;
  logic             q_full, q_not_empty, q_pop;
  job_t             q_head;
  logic [CNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_pulse_low_us      <= 20'd10000;
      cfg_r.temp_pulse_high_us     <= 20'd220000;
      cfg_r.temp_low_tenths        <= -12'sd400;
      cfg_r.temp_high_tenths       <= 12'sd1600;
      cfg_r.level_interval_low_us  <= 24'd1000000;
      cfg_r.level_interval_high_us <= 24'd3500000;
      cfg_r.level_low_tenths       <= 14'd0;
      cfg_r.level_high_tenths      <= 14'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP_PULSE_LOW:  cfg_r.temp_pulse_low_us      <= cfg_data[TPULSE_W-1:0];
        REG_TEMP_PULSE_HIGH: cfg_r.temp_pulse_high_us     <= cfg_data[TPULSE_W-1:0];
        REG_TEMP_LOW:        cfg_r.temp_low_tenths        <= cfg_data[TEMP_W-1:0];
        REG_TEMP_HIGH:       cfg_r.temp_high_tenths       <= cfg_data[TEMP_W-1:0];
        REG_LEVEL_INT_LOW:   cfg_r.level_interval_low_us  <= cfg_data[LINT_W-1:0];
        REG_LEVEL_INT_HIGH:  cfg_r.level_interval_high_us <= cfg_data[LINT_W-1:0];
        REG_LEVEL_LOW:       cfg_r.level_low_tenths       <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_HIGH:      cfg_r.level_high_tenths      <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  oilspd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  oilspd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (q_head),
    .count     (q_count)
  );

  oilspd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("job queue count beyond depth");

  a_no_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[75:30] == '0)
    else $error("level fields nonzero without level_present");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready)
    else $error("input ready while job queue is full");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

// File: sv/oilspd_front.sv
// Front end: accepts edge words, tracks rise times, classifies temperature pulses.
// Depends on oilspd_pkg; pushes jobs into oilspd_queue.
`timescale 1ns / 1ps

module oilspd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [oilspd_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] edge_time_us
  input  logic                                in_tuser,   // [0] pin_high
  input  logic                                q_full,
  output logic                                push,
  output oilspd_pkg::job_t                    push_job
);
  import oilspd_pkg::*;

  logic [TIME_W-1:0] last_rise_r, last_rise_nxt;
  logic [TIME_W-1:0] prev_rise_r, prev_rise_nxt;
  logic              prev_seen_r, prev_seen_nxt;
  logic [TIME_W-1:0] t;
  logic [TIME_W-1:0] width;
  logic              accept;
  logic              is_temp;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign t         = in_tdata[TIME_W-1:0];

  always_comb begin
    // modulo 2^32 difference handles wrapped timestamps
    width   = t - last_rise_r;
    is_temp = !in_tuser && (width >= WIDTH_MIN_US) && (width <= WIDTH_MAX_US);
    push    = accept && is_temp;

    push_job.temp_width_us     = width[TWIDTH_W-1:0];
    push_job.level_present     = prev_seen_r;
    push_job.level_interval_us = prev_seen_r ? (last_rise_r - prev_rise_r) : '0;

    last_rise_nxt = last_rise_r;
    prev_rise_nxt = prev_rise_r;
    prev_seen_nxt = prev_seen_r;
    if (accept && in_tuser) begin
      last_rise_nxt = t;
    end
    if (push) begin
      prev_rise_nxt = last_rise_r;
      prev_seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rise_r <= '0;
      prev_rise_r <= '0;
      prev_seen_r <= 1'b0;
    end else begin
      last_rise_r <= last_rise_nxt;
      prev_rise_r <= prev_rise_nxt;
      prev_seen_r <= prev_seen_nxt;
    end
  end

endmodule

// File: sv/oilspd_queue.sv
// Short job queue between the front end and the interpolation engine.
// Depends on oilspd_pkg (job_t).
`timescale 1ns / 1ps

module oilspd_queue #(
  parameter int unsigned DEPTH = oilspd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  oilspd_pkg::job_t              push_job,
  input  logic                          pop,
  output logic                          full,
  output logic                          not_empty,
  output oilspd_pkg::job_t              head_job,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import oilspd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = slot_r[rd_ptr_r];
  assign count     = count_r;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: sv/oilspd_back.sv
// Back end: clamped linear interpolation of temperature and oil level with one
// shared multiplier and a 14-step restoring divider; drives the output register.
// Depends on oilspd_pkg.
`timescale 1ns / 1ps

module oilspd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  oilspd_pkg::cfg_t                   cfg,
  input  logic                               q_not_empty,
  input  oilspd_pkg::job_t                   q_head,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [oilspd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser
);
  import oilspd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int unsigned PAD_W =
    OUT_TDATA_W - TEMP_W - TWIDTH_W - LEVEL_W - TIME_W;

  logic [2:0]              state_r, state_nxt;
  job_t                    job_r;
  logic                    sel_level_r;
  logic [MAG_W-1:0]        mag_r;
  logic [DX_W-1:0]         dx_r;
  logic [DX_W-1:0]         den_r;
  logic signed [Y_W-1:0]   y1_r;
  logic                    neg_r;
  logic [DX_W-1:0]         rem_r;
  logic [MAG_W-1:0]        low_r;   // dividend low bits, shifted out as quotient bits enter
  logic [STEP_W-1:0]       step_r;
  logic signed [Y_W-1:0]   res_r;
  logic [TEMP_W-1:0]       temp_r;
  logic [LEVEL_W-1:0]      level_r;
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic                    out_user_r;

  // operand selection for the current interpolation
  logic [TIME_W-1:0]       x, x1, x2;
  logic signed [Y_W-1:0]   y1, y2, dy;
  logic [Y_W-1:0]          dy_abs;
  logic [PROD_W-1:0]       prod;
  logic [DX_W:0]           trial;
  logic                    q_bit;
  logic signed [Y_W-1:0]   q_signed;
  logic                    out_free;

  always_comb begin
    if (sel_level_r) begin
      x  = job_r.level_interval_us;
      x1 = TIME_W'(cfg.level_interval_low_us);
      x2 = TIME_W'(cfg.level_interval_high_us);
      y1 = signed'(Y_W'(cfg.level_low_tenths));
      y2 = signed'(Y_W'(cfg.level_high_tenths));
    end else begin
      x  = TIME_W'(job_r.temp_width_us);
      x1 = TIME_W'(cfg.temp_pulse_low_us);
      x2 = TIME_W'(cfg.temp_pulse_high_us);
      y1 = Y_W'(cfg.temp_low_tenths);
      y2 = Y_W'(cfg.temp_high_tenths);
    end
    dy     = y2 - y1;
    dy_abs = dy[Y_W-1] ? Y_W'(-dy) : Y_W'(dy);
    prod   = PROD_W'(mag_r) * PROD_W'(dx_r);
    trial  = {rem_r, low_r[MAG_W-1]};
    q_bit  = (trial >= {1'b0, den_r});
    q_signed = neg_r ? -signed'(Y_W'(low_r)) : signed'(Y_W'(low_r));
  end

  assign out_free = !out_valid_r || out_tready;
  assign q_pop    = (state_r == S_IDLE) && q_not_empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_not_empty) state_nxt = S_SETUP;
      S_SETUP: begin
        // in range goes to the divider, clamped cases are stored directly
        if (x <= x1 || x >= x2) state_nxt = S_STORE;
        else                    state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_DIV;
      S_DIV:   if (step_r == STEP_W'(MAG_W - 1)) state_nxt = S_FIX;
      S_FIX:   state_nxt = S_STORE;
      S_STORE: begin
        if (!sel_level_r && job_r.level_present) state_nxt = S_SETUP;
        else                                     state_nxt = S_DONE;
      end
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        job_r       <= q_head;
        sel_level_r <= 1'b0;
        level_r     <= '0;
      end
      S_SETUP: begin
        if (x <= x1)      res_r <= y1;
        else if (x >= x2) res_r <= y2;
        y1_r  <= y1;
        neg_r <= dy[Y_W-1];
        mag_r <= dy_abs[MAG_W-1:0];
        dx_r  <= DX_W'(x - x1);
        den_r <= DX_W'(x2 - x1);
      end
      S_MUL: begin
        // quotient fits MAG_W bits, so the upper part is already below the divisor
        rem_r  <= prod[PROD_W-1:MAG_W];
        low_r  <= prod[MAG_W-1:0];
        step_r <= '0;
      end
      S_DIV: begin
        rem_r  <= q_bit ? DX_W'(trial - {1'b0, den_r}) : trial[DX_W-1:0];
        low_r  <= {low_r[MAG_W-2:0], q_bit};
        step_r <= step_r + 1'b1;
      end
      S_FIX: res_r <= y1_r + q_signed;
      S_STORE: begin
        if (sel_level_r) begin
          level_r <= res_r[LEVEL_W-1:0];
        end else begin
          temp_r      <= res_r[TEMP_W-1:0];
          sel_level_r <= 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_r <= {{PAD_W{1'b0}}, job_r.level_interval_us, level_r,
                         job_r.temp_width_us, temp_r};
          out_user_r <= job_r.level_present;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
